@@ hdl/spq_pkg.sv @@
// Shared types, constants and helpers of the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 16;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int PRIO_W  = PRIORITY_BITS;
    localparam int DATA_W  = 8;
    localparam int PIN_W   = 16;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_NOP  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [DATA_W-1:0]        data;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic [DATA_W-1:0]  data_out;
        t_status            status;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

    // Pass the incoming priority through as a signed value; it already has the slot width.
    function automatic logic signed [PRIO_W-1:0] decode_prio(input logic signed [PIN_W-1:0] raw);
        decode_prio = PRIO_W'(raw);
    endfunction

endpackage

@@ hdl/spq_store.sv @@
// Slot memory of the queue: one write port, one read port with registered data.
module spq_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [spq_pkg::IDX_W-1:0]  i_waddr,
    input  spq_pkg::t_entry            i_wdata,
    input  logic [spq_pkg::IDX_W-1:0]  i_raddr,
    output spq_pkg::t_entry            o_rdata
);
    import spq_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/spq_seq.sv @@
// Sequencer of the queue: walks the slot memory one entry at a time through a
// single priority comparator to insert, remove or read the head.
module spq_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  spq_pkg::t_req               i_req_type,
    input  logic [spq_pkg::DATA_W-1:0]  i_data,
    input  logic [spq_pkg::PIN_W-1:0]   i_prio,
    input  logic                        i_res_free,
    output logic                        o_res_valid,
    output spq_pkg::t_result            o_res
);
    import spq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD   = 9'b000000010,
        S_CMP  = 9'b000000100,
        S_PUT  = 9'b000001000,
        S_HRD  = 9'b000010000,
        S_HEAD = 9'b000100000,
        S_MRD  = 9'b001000000,
        S_MOV  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    t_entry              r_new, n_new;
    logic [DATA_W-1:0]   r_dout, n_dout;
    t_status             r_status, n_status;

    logic                we;
    logic [IDX_W-1:0]    waddr;
    t_entry              wdata;
    logic [IDX_W-1:0]    raddr;
    t_entry              rdata;
    logic                keep_ahead;

    spq_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // The one comparator: does the slot read stay ahead of the new entry.
    assign keep_ahead = (rdata.prio >= r_new.prio);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_new    = r_new;
        n_dout   = r_dout;
        n_status = r_status;
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = r_new;
        raddr    = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_new.data = i_data;
                    n_new.prio = decode_prio(i_prio);
                    n_dout     = '0;
                    n_status   = ST_OK;
                    case (i_req_type)
                        REQ_PUSH: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_idx   = r_count[IDX_W-1:0];
                                n_state = (r_count == '0) ? S_PUT : S_RD;
                            end
                        end
                        REQ_POP, REQ_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_idx   = (i_req_type == REQ_POP) ? IDX_W'(1) : '0;
                                n_state = S_HRD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                raddr   = r_idx - IDX_W'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (keep_ahead) begin
                    n_state = S_PUT;
                end else begin
                    // Move the lower-priority entry one slot toward the tail.
                    we    = 1'b1;
                    wdata = rdata;
                    n_idx = r_idx - IDX_W'(1);
                    n_state = (r_idx == IDX_W'(1)) ? S_PUT : S_RD;
                end
            end
            S_PUT: begin
                we      = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end
            S_HRD: begin
                raddr   = '0;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_dout = rdata.data;
                // r_idx is one on a pop and zero on a peek.
                if (r_idx == '0) begin
                    n_state = S_DONE;
                end else if (r_count == CNT_W'(1)) begin
                    n_count = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                raddr   = r_idx;
                n_state = S_MOV;
            end
            S_MOV: begin
                we    = 1'b1;
                waddr = r_idx - IDX_W'(1);
                wdata = rdata;
                if (CNT_W'(r_idx) == r_count - CNT_W'(1)) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_MRD;
                end
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_dout   <= n_dout;
        r_status <= n_status;
    end

    assign o_req_ready      = (r_state == S_IDLE);
    assign o_res_valid      = (r_state == S_DONE) && i_res_free;
    assign o_res.data_out   = r_dout;
    assign o_res.status     = r_status;
    assign o_res.is_empty   = (r_count == '0);
    assign o_res.entry_count = COUNT_W'(r_count);

endmodule

@@ hdl/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue with its stream ports and output register.
//
// The queue holds up to CAPACITY bytes, each with a signed priority, in a slot
// memory kept sorted by descending priority; equal priorities leave in arrival
// order. A request is a push, a pop or a peek (tuser), and every request gives
// exactly one result transfer carrying the byte, a status, an empty flag and the
// entry count. One request is worked on at a time by a sequencer that steps
// through the slot memory with a single read port, a single write port and one
// priority comparator; on a push each slot visited is read, then compared and
// written. A push moves each lower-priority entry one slot toward the tail
// before it writes the new one, a pop reads the head and then moves every other
// entry one slot toward the head, a peek reads only the head, and a dropped
// push, an empty pop or peek, or the unused request code go straight to the
// result. The result sits in an output register, so the next request is taken
// while it waits.
module sorted_priority_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request side.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] data_in, [23:8] priority_in
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    // Result side.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] data_out, [8] is_empty,
                                          // [13:9] entry_count, [15:14] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import spq_pkg::*;

    logic    res_free;
    logic    res_valid;
    t_result res;

    logic    r_m_valid;
    t_result r_m_res;

    // The output register can take a new result when empty or being drained.
    assign res_free = !r_m_valid || i_m_axis_tready;

    spq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req_type  (t_req'(i_s_axis_tuser)),
        .i_data      (i_s_axis_tdata[DATA_W-1:0]),
        .i_prio      (i_s_axis_tdata[DATA_W +: PIN_W]),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Hold the result until the downstream transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_free) begin
            r_m_valid <= res_valid;
        end
        if (res_free && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {2'b00, r_m_res.entry_count, r_m_res.is_empty, r_m_res.data_out};
    assign o_m_axis_tuser  = r_m_res.status;

endmodule
